>>> rtl/core/rcf_pkg.sv
// Package for the register command framer: command descriptor type,
// frame constants and the byte-wise CRC5 update function.
// No dependencies; used by every module under rtl/core.
package rcf_pkg;

  // Command kinds as carried on the input tuser bit.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Fixed frame bytes.
  localparam logic [7:0] SYNC_BYTE0    = 8'h55;
  localparam logic [7:0] SYNC_BYTE1    = 8'hAA;
  localparam logic [7:0] WRITE_LENGTH  = 8'h09;
  localparam logic [7:0] READ_LENGTH   = 8'h05;
  localparam logic [7:0] READ_TYPE_BIT = 8'h04;
  localparam logic [7:0] TYPE_RESET    = 8'h40;

  // CRC5 seed and feedback polynomial.
  localparam logic [4:0] CRC_INIT = 5'h1F;
  localparam logic [4:0] CRC_POLY = 5'h05;

  // Byte positions within a frame.
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_SYNC0   = 4'd0;
  localparam logic [IDX_W-1:0] IDX_SYNC1   = 4'd1;
  localparam logic [IDX_W-1:0] IDX_TYPE    = 4'd2;
  localparam logic [IDX_W-1:0] IDX_LENGTH  = 4'd3;
  localparam logic [IDX_W-1:0] IDX_CHIP    = 4'd4;
  localparam logic [IDX_W-1:0] IDX_REG     = 4'd5;
  localparam logic [IDX_W-1:0] IDX_VAL3    = 4'd6;
  localparam logic [IDX_W-1:0] IDX_VAL2    = 4'd7;
  localparam logic [IDX_W-1:0] IDX_VAL1    = 4'd8;
  localparam logic [IDX_W-1:0] IDX_VAL0    = 4'd9;
  localparam logic [IDX_W-1:0] IDX_WR_LAST = 4'd10;
  localparam logic [IDX_W-1:0] IDX_RD_LAST = 4'd6;

  // One classified command, as handed from the front to the back.
  typedef struct packed {
    logic        kind;
    logic [7:0]  type_byte;
    logic [7:0]  length;
    logic [7:0]  chip_address;
    logic [7:0]  register_address;
    logic [31:0] register_value;
  } cmd_t;

  // Advance the CRC5 over one byte, most significant bit first.
  function automatic logic [4:0] crc5_byte(input logic [4:0] crc_in,
                                           input logic [7:0] data);
    logic [4:0] crc;
    logic       fb;
    crc = crc_in;
    for (int b = 7; b >= 0; b--) begin
      fb  = crc[4] ^ data[b];
      crc = {crc[3:0], 1'b0} ^ (fb ? CRC_POLY : 5'h00);
    end
    return crc;
  endfunction

endpackage

>>> rtl/core/rcf_front.sv
// Front end of the framer: holds the type register and classifies each
// command into a descriptor for the queue. Depends on rcf_pkg.
module rcf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  input  logic              kind,
  input  logic [7:0]        chip_address,
  input  logic [7:0]        register_address,
  input  logic [31:0]       register_value,
  output rcf_pkg::cmd_t     cmd
);

  logic [7:0] type_base;

  // The type register takes a write on every beat of the config channel.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_base <= rcf_pkg::TYPE_RESET;
    end else if (cfg_valid) begin
      type_base <= cfg_data;
    end
  end

  // Reads carry the read bit in the type byte and a shorter length.
  always_comb begin
    cmd.kind             = kind;
    cmd.chip_address     = chip_address;
    cmd.register_address = register_address;
    cmd.register_value   = register_value;
    if (kind == rcf_pkg::KIND_READ) begin
      cmd.type_byte = type_base | rcf_pkg::READ_TYPE_BIT;
      cmd.length    = rcf_pkg::READ_LENGTH;
    end else begin
      cmd.type_byte = type_base;
      cmd.length    = rcf_pkg::WRITE_LENGTH;
    end
  end

endmodule

>>> rtl/core/rcf_queue.sv
// Small command queue between front and back, built from registers.
// Depends on rcf_pkg for the descriptor type.
module rcf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rcf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rcf_pkg::cmd_t head_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rcf_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count; push and pop may share a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/rcf_back.sv
// Back end of the framer: walks the head command byte by byte, runs the
// CRC5 and drives the registered output stream. Depends on rcf_pkg.
module rcf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  rcf_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic          m_tlast
);

  logic [rcf_pkg::IDX_W-1:0] idx;
  logic [4:0]                crc;
  logic [4:0]                crc_in;
  logic [4:0]                crc_next;
  logic [rcf_pkg::IDX_W-1:0] last_idx;
  logic                      is_last;
  logic                      advance;
  logic [7:0]                frame_byte;

  assign last_idx = (head_cmd.kind == rcf_pkg::KIND_READ) ? rcf_pkg::IDX_RD_LAST
                                                         : rcf_pkg::IDX_WR_LAST;
  assign is_last  = (idx == last_idx);
  assign advance  = head_valid && (!m_tvalid || m_tready);
  assign pop      = advance && is_last;

  // Byte for the current position; the last position carries the CRC.
  always_comb begin
    if (is_last) begin
      frame_byte = {crc, 3'b000};
    end else begin
      case (idx)
        rcf_pkg::IDX_SYNC0:  frame_byte = rcf_pkg::SYNC_BYTE0;
        rcf_pkg::IDX_SYNC1:  frame_byte = rcf_pkg::SYNC_BYTE1;
        rcf_pkg::IDX_TYPE:   frame_byte = head_cmd.type_byte;
        rcf_pkg::IDX_LENGTH: frame_byte = head_cmd.length;
        rcf_pkg::IDX_CHIP:   frame_byte = head_cmd.chip_address;
        rcf_pkg::IDX_REG:    frame_byte = head_cmd.register_address;
        rcf_pkg::IDX_VAL3:   frame_byte = head_cmd.register_value[31:24];
        rcf_pkg::IDX_VAL2:   frame_byte = head_cmd.register_value[23:16];
        rcf_pkg::IDX_VAL1:   frame_byte = head_cmd.register_value[15:8];
        rcf_pkg::IDX_VAL0:   frame_byte = head_cmd.register_value[7:0];
        default:             frame_byte = 8'h00;
      endcase
    end
  end

  // The CRC restarts on the type byte; earlier values are overwritten.
  assign crc_in   = (idx == rcf_pkg::IDX_TYPE) ? rcf_pkg::CRC_INIT : crc;
  assign crc_next = rcf_pkg::crc5_byte(crc_in, frame_byte);

  // Sequencer position and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
      idx      <= is_last ? '0 : idx + 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= frame_byte;
      m_tlast <= is_last;
      crc     <= crc_next;
    end
  end

endmodule

>>> rtl/core/register_command_framer_crc5_top.sv
// Register command framer with CRC5 trailer, top level.
// Commands queue up to QUEUE_DEPTH; the first byte of a frame passes a queue
// entry and the output register. One output byte per cycle while a command
// waits and m_tready accepts; a write frame is 11 bytes, a read frame 7.
// Reset (rst, synchronous): empties the queue and output, type byte to 0x40.
// Depends on rcf_pkg, rcf_front, rcf_queue and rcf_back.
module register_command_framer_crc5_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: command_type_byte.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Command input.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // chip_address[7:0], register_address[15:8],
                                // register_value[47:16]
  input  logic        s_tuser,  // kind
  // Frame byte output.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // frame_byte[7:0]
  output logic        m_tlast   // last_byte
);

  rcf_pkg::cmd_t front_cmd;
  rcf_pkg::cmd_t head_cmd;
  logic          queue_full;
  logic          head_valid;
  logic          pop;
  logic          push;

  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;

  rcf_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .kind             (s_tuser),
    .chip_address     (s_tdata[7:0]),
    .register_address (s_tdata[15:8]),
    .register_value   (s_tdata[47:16]),
    .cmd              (front_cmd)
  );

  rcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  rcf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
